@@ rtl/core/usbtdb_pkg.sv @@
// usbtdb_pkg: shared types, constants and helpers for the transfer-descriptor builder.
// Depends on nothing; every other file of the block imports it.
package usbtdb_pkg;

  localparam int unsigned LEN_W = 17;   // transfer length / buffer offset
  localparam int unsigned MPS_W = 11;   // packet size
  localparam int unsigned DVD_W = 18;   // length + packet size - 1
  localparam int unsigned CNT_W = 7;    // descriptors per chain, 1..64
  localparam int unsigned RESULT_LIMIT = 64;

  localparam logic [MPS_W-1:0] MPS_CTRL_DEF = 11'd64;
  localparam logic [MPS_W-1:0] MPS_BULK_DEF = 11'd512;
  localparam logic [14:0]      SETUP_BYTES  = 15'd8;
  localparam logic [1:0]       CERR_MAX     = 2'd3;
  localparam logic [1:0]       EPS_HIGH     = 2'd2;   // endpoint speed field

  localparam logic       REQ_CONTROL = 1'b0;
  localparam logic       REQ_BULK    = 1'b1;

  localparam logic [1:0] PID_OUT   = 2'd0;
  localparam logic [1:0] PID_IN    = 2'd1;
  localparam logic [1:0] PID_SETUP = 2'd2;

  localparam logic [1:0] KIND_SETUP  = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  typedef struct packed {
    logic             req_type;
    logic [LEN_W-1:0] transfer_length;
    logic [MPS_W-1:0] pkt_size;
    logic             direction_in;
    logic [3:0]       endpoint_number;
    logic [6:0]       device_address;
    logic             start_toggle;
  } usbtdb_req_t;

  typedef struct packed {
    logic [7:0]       ring_index;
    logic [7:0]       next_index;
    logic             next_terminate;
    logic [31:0]      token_word;
    logic [1:0]       descriptor_kind;
    logic [LEN_W-1:0] buffer_offset;
    logic [31:0]      endpoint_char_word;
    logic             final_toggle;
    logic             rejected;
    logic             last;
  } usbtdb_res_t;

  // Classified request handed from front to back.
  typedef struct packed {
    logic             req_type;
    logic             direction_in;
    logic             start_toggle;
    logic             final_toggle;
    logic             rejected;
    logic [LEN_W-1:0] length;
    logic [MPS_W-1:0] mps;
    logic [31:0]      epchar;
    logic [CNT_W-1:0] count;
  } usbtdb_job_t;

  // qTD token: dt | bytes | ioc | cerr | pid | active
  function automatic logic [31:0] make_token(input logic dt, input logic [14:0] bytes,
                                             input logic ioc, input logic [1:0] pid);
    make_token = {dt, bytes, ioc, 3'b000, CERR_MAX, pid, 1'b1, 7'b0000000};
  endfunction

endpackage

@@ rtl/core/usbtdb_front.sv @@
// usbtdb_front: accepts requests, applies packet-size defaults and works out the chain length.
// Uses usbtdb_pkg; a restoring divider gives ceil(length / packet size) one bit per cycle.
module usbtdb_front #(
  parameter int unsigned MAX_CONTROL_DESCRIPTORS = 64,
  parameter int unsigned MAX_BULK_DESCRIPTORS    = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  output logic                      full_o,
  input  usbtdb_pkg::usbtdb_req_t   req_i,
  output logic                      job_valid_o,
  input  logic                      job_ready_i,
  output usbtdb_pkg::usbtdb_job_t   job_o
);
  import usbtdb_pkg::*;

  localparam int unsigned CTRL_LIM = (MAX_CONTROL_DESCRIPTORS < RESULT_LIMIT) ?
                                     MAX_CONTROL_DESCRIPTORS : RESULT_LIMIT;
  localparam int unsigned BULK_LIM = (MAX_BULK_DESCRIPTORS < RESULT_LIMIT) ?
                                     MAX_BULK_DESCRIPTORS : RESULT_LIMIT;
  localparam logic [DVD_W-1:0] CTRL_MAXQ = DVD_W'(CTRL_LIM - 2);
  localparam logic [DVD_W-1:0] BULK_MAXQ = DVD_W'(BULK_LIM);
  localparam logic [CNT_W-1:0] BULK_CAP  = CNT_W'(BULK_LIM);
  localparam logic [4:0]       LAST_STEP = 5'(DVD_W - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [4:0]       step_q, step_d;
  usbtdb_req_t      req_q, req_d;
  logic [DVD_W-1:0] dvd_q, dvd_d, quo_q, quo_d;
  logic [MPS_W:0]   rem_q, rem_d;
  logic [MPS_W-1:0] mps_in;
  logic [MPS_W:0]   trial;
  logic             fits;
  logic [CNT_W-1:0] n_bulk;

  assign full_o = (state_q != ST_IDLE);

  always_comb begin
    mps_in = req_i.pkt_size;
    if (req_i.pkt_size == '0) begin
      mps_in = (req_i.req_type == REQ_CONTROL) ? MPS_CTRL_DEF : MPS_BULK_DEF;
    end
  end

  assign trial = {rem_q[MPS_W-1:0], dvd_q[DVD_W-1]};
  assign fits  = (trial >= {1'b0, req_q.pkt_size});

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    req_d   = req_q;
    dvd_d   = dvd_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    case (state_q)
      ST_IDLE: begin
        if (push_i) begin
          req_d          = req_i;
          req_d.pkt_size = mps_in;
          dvd_d          = {1'b0, req_i.transfer_length} + DVD_W'(mps_in) - DVD_W'(1);
          quo_d          = '0;
          rem_d          = '0;
          step_d         = '0;
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d  = fits ? trial - {1'b0, req_q.pkt_size} : trial;
        quo_d  = {quo_q[DVD_W-2:0], fits};
        dvd_d  = {dvd_q[DVD_W-2:0], 1'b0};
        step_d = step_q + 5'd1;
        if (step_q == LAST_STEP) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (job_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Bulk chain length from the quotient.
  always_comb begin
    if (quo_q == '0) begin
      n_bulk = CNT_W'(1);
    end else if (quo_q > BULK_MAXQ) begin
      n_bulk = BULK_CAP;
    end else begin
      n_bulk = quo_q[CNT_W-1:0];
    end
  end

  always_comb begin
    job_o              = '0;
    job_o.req_type     = req_q.req_type;
    job_o.direction_in = req_q.direction_in;
    job_o.length       = req_q.transfer_length;
    job_o.mps          = req_q.pkt_size;
    if (req_q.req_type == REQ_CONTROL) begin
      job_o.epchar   = {5'b0, req_q.pkt_size, 1'b0, 1'b1, EPS_HIGH, 4'b0000, 1'b0,
                        req_q.device_address};
      job_o.rejected = (quo_q > CTRL_MAXQ);
      job_o.count    = quo_q[CNT_W-1:0] + CNT_W'(2);
    end else begin
      job_o.epchar       = {5'b0, req_q.pkt_size, 2'b00, EPS_HIGH, req_q.endpoint_number,
                            1'b0, req_q.device_address};
      job_o.start_toggle = req_q.start_toggle;
      job_o.final_toggle = req_q.start_toggle ^ n_bulk[0];
      job_o.count        = n_bulk;
    end
  end

  assign job_valid_o = (state_q == ST_DONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

endmodule

@@ rtl/core/usbtdb_jobq.sv @@
// usbtdb_jobq: two-entry queue of classified requests between front and back.
// Uses usbtdb_pkg for the job type.
module usbtdb_jobq (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    wr_valid_i,
  output logic                    wr_ready_o,
  input  usbtdb_pkg::usbtdb_job_t wr_job_i,
  output logic                    rd_valid_o,
  input  logic                    rd_ready_i,
  output usbtdb_pkg::usbtdb_job_t rd_job_o
);
  import usbtdb_pkg::*;

  usbtdb_job_t entry_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  fill_q;
  logic        do_wr, do_rd;

  assign wr_ready_o = (fill_q != 2'd2);
  assign rd_valid_o = (fill_q != 2'd0);
  assign rd_job_o   = entry_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_ready_i && rd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= ~wr_ptr_q;
      if (do_rd) rd_ptr_q <= ~rd_ptr_q;
      fill_q <= fill_q + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entry_q[wr_ptr_q] <= wr_job_i;
    end
  end

endmodule

@@ rtl/core/usbtdb_back.sv @@
// usbtdb_back: walks one classified request, one descriptor per cycle while not stalled by pop,
// into an output register. Uses usbtdb_pkg; keeps the ring's next-free slot.
module usbtdb_back #(
  parameter int unsigned RING_ENTRIES = 256
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    job_valid_i,
  output logic                    job_ready_o,
  input  usbtdb_pkg::usbtdb_job_t job_i,
  output logic                    empty,
  input  logic                    pop,
  output usbtdb_pkg::usbtdb_res_t res_o
);
  import usbtdb_pkg::*;

  localparam int unsigned IDX_W = $clog2(RING_ENTRIES);
  localparam logic [IDX_W-1:0] SLOT_MAX = IDX_W'(RING_ENTRIES - 1);

  logic             busy_q;
  usbtdb_job_t      job_q;
  logic [CNT_W-1:0] k_q;
  logic [IDX_W-1:0] slot_q, slot_nx;
  logic [LEN_W-1:0] off_q, rem_q;
  logic             tog_q;
  logic             out_valid_q;
  usbtdb_res_t      res_q, res_d;
  logic             advance, fire, chain_end, is_data;
  logic [1:0]       kind;
  logic [MPS_W-1:0] chunk;
  logic [1:0]       pid_data, pid_status;

  assign advance     = !out_valid_q || pop;
  assign fire        = busy_q && advance;
  assign job_ready_o = !busy_q;
  assign empty       = !out_valid_q;
  assign res_o       = res_q;

  assign slot_nx    = (slot_q == SLOT_MAX) ? '0 : slot_q + IDX_W'(1);
  assign chain_end  = job_q.rejected || ((k_q + CNT_W'(1)) == job_q.count);
  assign chunk      = (rem_q > LEN_W'(job_q.mps)) ? job_q.mps : rem_q[MPS_W-1:0];
  assign pid_data   = job_q.direction_in ? PID_IN : PID_OUT;
  assign pid_status = job_q.direction_in ? PID_OUT : PID_IN;

  always_comb begin
    kind = KIND_DATA;
    if (job_q.req_type == REQ_CONTROL) begin
      if (k_q == '0) begin
        kind = KIND_SETUP;
      end else if (chain_end) begin
        kind = KIND_STATUS;
      end
    end
  end
  assign is_data = (kind == KIND_DATA);

  always_comb begin
    res_d = '0;
    res_d.endpoint_char_word = job_q.epchar;
    res_d.last               = chain_end;
    if (job_q.rejected) begin
      res_d.rejected = 1'b1;
    end else begin
      res_d.ring_index      = 8'(slot_q);
      res_d.next_index      = chain_end ? 8'd0 : 8'(slot_nx);
      res_d.next_terminate  = chain_end;
      res_d.descriptor_kind = kind;
      res_d.final_toggle    = job_q.final_toggle;
      case (kind)
        KIND_SETUP:  res_d.token_word = make_token(1'b0, SETUP_BYTES, 1'b0, PID_SETUP);
        KIND_STATUS: res_d.token_word = make_token(1'b1, 15'd0, 1'b1, pid_status);
        default: begin
          res_d.token_word    = make_token(tog_q, 15'(chunk),
                                           job_q.req_type == REQ_BULK, pid_data);
          res_d.buffer_offset = off_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (!busy_q && job_valid_i) begin
        busy_q <= 1'b1;
      end else if (fire && chain_end) begin
        busy_q <= 1'b0;
      end
      if (fire && !job_q.rejected) begin
        slot_q <= slot_nx;
      end
      if (advance) begin
        out_valid_q <= busy_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && job_valid_i) begin
      job_q <= job_i;
      k_q   <= '0;
      off_q <= '0;
      rem_q <= job_i.length;
      tog_q <= (job_i.req_type == REQ_CONTROL) ? 1'b1 : job_i.start_toggle;
    end else if (fire) begin
      k_q <= k_q + CNT_W'(1);
      if (is_data) begin
        off_q <= off_q + LEN_W'(job_q.mps);
        rem_q <= rem_q - LEN_W'(chunk);
        tog_q <= ~tog_q;
      end
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

endmodule

@@ rtl/core/usb_transfer_descriptor_builder.sv @@
// usb_transfer_descriptor_builder: top level, front classifier, job queue and back emitter.
// Uses usbtdb_pkg, usbtdb_front, usbtdb_jobq and usbtdb_back.
//
// Usage
//   Request side: an item (req_i) is taken on a clock edge with push high and full low.
//   Result side: while empty is low the oldest descriptor sits on res_o; it is taken on
//   an edge with pop high. Each request yields one descriptor per ring slot it uses,
//   or a single rejected item for an over-long control chain; 'last' marks its end.
// Flow
//   The front latches a request, then runs the bit-serial divider that turns length
//   and packet size into a chunk count, and then hands the job on.
//   A two-entry job queue sits between front and back, so the front works on the next
//   request while the back is still emitting.
//   The back loads a job, then emits one descriptor per cycle while the result
//   register is free or being popped.
// Stalls and reset
//   The result register holds while pop is low; the back stalls behind it and the
//   front and queue fill, after which full stays high. Reset empties everything and
//   sets the ring's next-free slot to zero.
module usb_transfer_descriptor_builder #(
  parameter int unsigned RING_ENTRIES            = 256,
  parameter int unsigned MAX_CONTROL_DESCRIPTORS = 64,
  parameter int unsigned MAX_BULK_DESCRIPTORS    = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  usbtdb_pkg::usbtdb_req_t req_i,
  output logic                    empty,
  input  logic                    pop,
  output usbtdb_pkg::usbtdb_res_t res_o
);
  import usbtdb_pkg::*;

  // front -> queue
  logic        fq_valid, fq_ready;
  usbtdb_job_t fq_job;
  // queue -> back
  logic        qb_valid, qb_ready;
  usbtdb_job_t qb_job;

  // Classification and chunk-count division.
  usbtdb_front #(
    .MAX_CONTROL_DESCRIPTORS(MAX_CONTROL_DESCRIPTORS),
    .MAX_BULK_DESCRIPTORS   (MAX_BULK_DESCRIPTORS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .req_i      (req_i),
    .job_valid_o(fq_valid),
    .job_ready_i(fq_ready),
    .job_o      (fq_job)
  );

  // Decouples the two halves.
  usbtdb_jobq u_jobq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(fq_valid),
    .wr_ready_o(fq_ready),
    .wr_job_i  (fq_job),
    .rd_valid_o(qb_valid),
    .rd_ready_i(qb_ready),
    .rd_job_o  (qb_job)
  );

  // Descriptor emission and ring bookkeeping.
  usbtdb_back #(
    .RING_ENTRIES(RING_ENTRIES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(qb_valid),
    .job_ready_o(qb_ready),
    .job_i      (qb_job),
    .empty      (empty),
    .pop        (pop),
    .res_o      (res_o)
  );

endmodule

@@ rtl/core/usbtdb_checker.sv @@
// usbtdb_checker: port-level checks of the descriptor builder, bound to the top level.
// Uses usbtdb_pkg for the result type.
module usbtdb_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    empty,
  input logic                    pop,
  input usbtdb_pkg::usbtdb_res_t res_o
);
  import usbtdb_pkg::*;

  // A rejected request is a lone item with no ring slot.
  a_reject_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_o.rejected) |-> (res_o.last && !res_o.next_terminate &&
                                    res_o.ring_index == 8'd0))
    else $error("rejected item malformed");

  // Chain end and link terminate coincide.
  a_term_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !res_o.rejected) |-> (res_o.next_terminate == res_o.last))
    else $error("terminate and last disagree");

  a_term_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_o.next_terminate) |-> (res_o.next_index == 8'd0))
    else $error("terminated link not zero");

  // Descriptors of one chain are linked slot to slot.
  a_chain_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(pop && !empty && !res_o.last) && !empty) |->
      (res_o.ring_index == $past(res_o.next_index)))
    else $error("chain link broken");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(res_o)))
    else $error("result changed while stalled");

endmodule

bind usb_transfer_descriptor_builder usbtdb_checker u_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .empty (empty),
  .pop   (pop),
  .res_o (res_o)
);

@@ verif/tb_top.sv @@
// tb_top: self-checking testbench for usb_transfer_descriptor_builder.
// Drives requests, predicts every qTD item of each chain and checks it on arrival.
// Depends on usbtdb_pkg and the usb_transfer_descriptor_builder RTL.
`timescale 1ns / 1ps

module tb_top;
  import usbtdb_pkg::*;

  localparam int unsigned RING_SLOTS   = 256;
  localparam int unsigned MAX_CTRL_TDS = 64;
  localparam int unsigned MAX_BULK_TDS = 64;
  localparam int unsigned LEN_MAX      = (1 << LEN_W) - 1;
  localparam int unsigned RAND_REQS    = 100;
  localparam int unsigned DRAIN_CYCLES = 40;    // front plus back latency, with margin
  localparam logic [31:0] DTC_BIT      = 32'h0000_4000;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        push  = 1'b0;
  logic        full;
  usbtdb_req_t req   = '0;
  logic        empty;
  logic        pop   = 1'b0;
  usbtdb_res_t res;

  // Requests waiting for the driver, and descriptors waiting for the monitor.
  usbtdb_req_t pending_reqs[$];
  usbtdb_res_t descriptor_q[$];

  // Predictor state: ring's next free slot.
  int unsigned next_free_slot = 0;
  int unsigned error_count    = 0;

  usb_transfer_descriptor_builder #(
    .RING_ENTRIES           (RING_SLOTS),
    .MAX_CONTROL_DESCRIPTORS(MAX_CTRL_TDS),
    .MAX_BULK_DESCRIPTORS   (MAX_BULK_TDS)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .push  (push),
    .full  (full),
    .req_i (req),
    .empty (empty),
    .pop   (pop),
    .res_o (res)
  );

  // 20 ns clock.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------

  // qTD token: toggle at 31, byte count 30:16, ioc 15, cerr 11:10, pid 9:8, active 7.
  function automatic logic [31:0] qtd_token(input logic dt, input logic [14:0] nbytes,
                                            input logic ioc, input logic [1:0] pid);
    logic [31:0] tok;
    tok = 32'h0000_0080;
    tok |= 32'(CERR_MAX) << 10;
    tok |= 32'(pid) << 8;
    tok |= 32'(ioc) << 15;
    tok |= 32'(nbytes) << 16;
    tok |= 32'(dt) << 31;
    return tok;
  endfunction

  // One descriptor of a chain of 'count', placed at slot base + k of the ring.
  function automatic void queue_td(input int unsigned k, input int unsigned count,
                                   input logic [31:0] token, input logic [1:0] kind,
                                   input int unsigned offset, input logic [31:0] epchar,
                                   input logic ftog);
    usbtdb_res_t td;
    logic        chain_end;
    chain_end             = (k + 1 >= count);
    td.ring_index         = 8'((next_free_slot + k) % RING_SLOTS);
    td.next_index         = chain_end ? 8'd0 : 8'((next_free_slot + k + 1) % RING_SLOTS);
    td.next_terminate     = chain_end;
    td.token_word         = token;
    td.descriptor_kind    = kind;
    td.buffer_offset      = offset[LEN_W-1:0];
    td.endpoint_char_word = epchar;
    td.final_toggle       = ftog;
    td.rejected           = 1'b0;
    td.last               = chain_end;
    descriptor_q.push_back(td);
  endfunction

  // Works out the whole chain for one accepted request and advances the ring unless it is rejected.
  function automatic void build_chain(input usbtdb_req_t rq);
    int unsigned mps, len, count, ndata, off, chunk, k;
    logic [31:0] epchar;
    logic [1:0]  pid_data, tail_pid;
    logic        tog, ftog;
    usbtdb_res_t rej;
    mps      = rq.pkt_size;
    len      = rq.transfer_length;
    tog      = rq.start_toggle;
    pid_data = rq.direction_in ? PID_IN : PID_OUT;
    tail_pid = rq.direction_in ? PID_OUT : PID_IN;
    if (rq.req_type == REQ_CONTROL) begin
      if (mps == 0) mps = MPS_CTRL_DEF;
      // control: dtc set, endpoint forced to 0
      epchar = (32'(mps) << 16) | (32'(EPS_HIGH) << 12) | DTC_BIT | 32'(rq.device_address);
      ndata  = (len + mps - 1) / mps;
      count  = ndata + 2;
      if (count > MAX_CTRL_TDS || count > RESULT_LIMIT) begin
        // too long: one rejected item, ring untouched
        rej                    = '0;
        rej.endpoint_char_word = epchar;
        rej.rejected           = 1'b1;
        rej.last               = 1'b1;
        descriptor_q.push_back(rej);
        return;
      end
      queue_td(0, count, qtd_token(1'b0, SETUP_BYTES, 1'b0, PID_SETUP), KIND_SETUP, 0,
               epchar, 1'b0);
      tog = 1'b1;
      for (k = 0; k < ndata; k++) begin
        off   = k * mps;
        chunk = len - off;
        if (chunk > mps) chunk = mps;
        queue_td(k + 1, count, qtd_token(tog, 15'(chunk), 1'b0, pid_data), KIND_DATA, off,
                 epchar, 1'b0);
        tog = ~tog;
      end
      queue_td(count - 1, count, qtd_token(1'b1, 15'd0, 1'b1, tail_pid), KIND_STATUS, 0,
               epchar, 1'b0);
    end else begin
      if (mps == 0) mps = MPS_BULK_DEF;
      epchar = (32'(mps) << 16) | (32'(EPS_HIGH) << 12) | (32'(rq.endpoint_number) << 8) |
               32'(rq.device_address);
      count = (len + mps - 1) / mps;
      if (count < 1) count = 1;
      if (count > MAX_BULK_TDS) count = MAX_BULK_TDS;
      if (count > RESULT_LIMIT) count = RESULT_LIMIT;
      ftog = tog ^ count[0];
      for (k = 0; k < count; k++) begin
        off   = k * mps;
        chunk = (off < len) ? len - off : 0;
        if (chunk > mps) chunk = mps;
        // an empty chunk points at offset 0
        queue_td(k, count, qtd_token(tog, 15'(chunk), 1'b1, pid_data), KIND_DATA,
                 (chunk != 0) ? off : 0, epchar, ftog);
        tog = ~tog;
      end
    end
    next_free_slot = (next_free_slot + count) % RING_SLOTS;
  endfunction

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------

  task automatic add_req(input logic rtype, input int unsigned len, input int unsigned mps,
                         input logic dir, input int unsigned ep, input int unsigned addr,
                         input logic tog);
    usbtdb_req_t rq;
    rq.req_type        = rtype;
    rq.transfer_length = LEN_W'(len);
    rq.pkt_size        = MPS_W'(mps);
    rq.direction_in    = dir;
    rq.endpoint_number = 4'(ep);
    rq.device_address  = 7'(addr);
    rq.start_toggle    = tog;
    pending_reqs.push_back(rq);
  endtask

  // Random request; lengths are mostly tied to the packet size so that chains of every
  // size up to the cap turn up, plus full-range lengths and zero lengths.
  task automatic add_random_req();
    int unsigned mps, eff, len;
    logic        rtype;
    rtype = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0, 1:    mps = 0;
      2:       mps = 1024;
      3:       mps = $urandom_range(1, 16);
      default: mps = $urandom_range(1, 1023);
    endcase
    eff = (mps != 0) ? mps : ((rtype == REQ_CONTROL) ? MPS_CTRL_DEF : MPS_BULK_DEF);
    case ($urandom_range(0, 9))
      0, 1, 2: len = $urandom_range(0, eff * 4);
      3, 4, 5, 6: len = $urandom_range(0, eff * 66);
      7:       len = $urandom_range(0, LEN_MAX);
      8:       len = eff * $urandom_range(0, 64);   // exact multiples, cap boundaries
      default: len = 0;
    endcase
    if (len > LEN_MAX) len = LEN_MAX;
    add_req(rtype, len, mps, 1'($urandom_range(0, 1)), $urandom_range(0, 15),
            $urandom_range(0, 127), 1'($urandom_range(0, 1)));
  endtask

  // ------------------------------------------------------------------
  // Driver: bursts of items with random gaps between them
  // ------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      push <= 1'b0;
      req  <= '0;
    end else begin
      // the item on req is taken at this edge: predict its chain now
      if (push && !full) build_chain(req);
      if (!push || !full) begin
        if (gap_left != 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          push <= 1'b1;
          req  <= pending_reqs.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 12);
            // a quarter of the bursts run straight into the next one
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end else begin
            burst_left--;
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Monitor: pop follows a rotating stall pattern, reloaded after each full rotation, that picks the stall cycles
  // ------------------------------------------------------------------
  logic [31:0] stall_pat   = '1;
  int unsigned stall_phase = 0;

  task automatic check_descriptor(input usbtdb_res_t got);
    usbtdb_res_t exp;
    if (descriptor_q.size() == 0) begin
      $error("descriptor with nothing expected: ring_index %0d", got.ring_index);
      error_count++;
      return;
    end
    exp = descriptor_q.pop_front();
    if (got.ring_index !== exp.ring_index) begin
      $error("ring_index: expected %0d, actual %0d", exp.ring_index, got.ring_index);
      error_count++;
    end
    if (got.next_index !== exp.next_index) begin
      $error("next_index: expected %0d, actual %0d", exp.next_index, got.next_index);
      error_count++;
    end
    if (got.next_terminate !== exp.next_terminate) begin
      $error("next_terminate: expected %0d, actual %0d", exp.next_terminate,
             got.next_terminate);
      error_count++;
    end
    if (got.token_word !== exp.token_word) begin
      $error("token_word: expected %h, actual %h", exp.token_word, got.token_word);
      error_count++;
    end
    if (got.descriptor_kind !== exp.descriptor_kind) begin
      $error("descriptor_kind: expected %0d, actual %0d", exp.descriptor_kind,
             got.descriptor_kind);
      error_count++;
    end
    if (got.buffer_offset !== exp.buffer_offset) begin
      $error("buffer_offset: expected %0d, actual %0d", exp.buffer_offset,
             got.buffer_offset);
      error_count++;
    end
    if (got.endpoint_char_word !== exp.endpoint_char_word) begin
      $error("endpoint_char_word: expected %h, actual %h", exp.endpoint_char_word,
             got.endpoint_char_word);
      error_count++;
    end
    if (got.final_toggle !== exp.final_toggle) begin
      $error("final_toggle: expected %0d, actual %0d", exp.final_toggle, got.final_toggle);
      error_count++;
    end
    if (got.rejected !== exp.rejected) begin
      $error("rejected: expected %0d, actual %0d", exp.rejected, got.rejected);
      error_count++;
    end
    if (got.last !== exp.last) begin
      $error("last: expected %0d, actual %0d", exp.last, got.last);
      error_count++;
    end
  endtask

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_descriptor(res);
      if (stall_phase == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pat = '1;                    // no stalls at all
          1:       stall_pat = $urandom;
          2:       stall_pat = $urandom | $urandom;   // light stalling
          default: stall_pat = $urandom & $urandom;   // heavy stalling
        endcase
        stall_phase = 32;
      end
      pop <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[31:1]};
      stall_phase--;
    end
  end

  // ------------------------------------------------------------------
  // Sequence: directed items, random items, drain, verdict
  // ------------------------------------------------------------------
  initial begin
    int unsigned i;

    // control: no data stage, only setup and status
    add_req(REQ_CONTROL, 0, 0, 1'b0, 0, 0, 1'b0);
    // control: one small chunk, endpoint field must be ignored
    add_req(REQ_CONTROL, 8, 8, 1'b1, 15, 127, 1'b1);
    // control: exactly the chain limit with the default packet size
    add_req(REQ_CONTROL, 62 * 64, 0, 1'b1, 3, 5, 1'b0);
    // control: one byte over the limit, rejected
    add_req(REQ_CONTROL, 62 * 64 + 1, 0, 1'b0, 0, 64, 1'b0);
    // control: longest length, largest packet, still rejected
    add_req(REQ_CONTROL, LEN_MAX, 1024, 1'b1, 0, 127, 1'b1);
    // control: exactly the limit with the largest packet
    add_req(REQ_CONTROL, 62 * 1024, 1024, 1'b0, 9, 1, 1'b0);
    // control: one-byte packets, short partial chain
    add_req(REQ_CONTROL, 5, 1, 1'b0, 0, 42, 1'b1);
    add_req(REQ_CONTROL, LEN_MAX, 1, 1'b1, 0, 0, 1'b0);
    add_req(REQ_CONTROL, 64, 0, 1'b0, 0, 127, 1'b0);
    add_req(REQ_CONTROL, 100, 1023, 1'b1, 4, 8, 1'b1);
    // bulk: zero length still gives one empty chunk
    add_req(REQ_BULK, 0, 0, 1'b0, 0, 0, 1'b0);
    add_req(REQ_BULK, 0, 1024, 1'b1, 15, 127, 1'b1);
    // bulk: chunk count capped
    add_req(REQ_BULK, LEN_MAX, 0, 1'b1, 1, 2, 1'b1);
    add_req(REQ_BULK, LEN_MAX, 1024, 1'b0, 15, 127, 1'b0);
    // bulk: exactly at the cap, and one byte over it
    add_req(REQ_BULK, 64 * 1024, 1024, 1'b1, 7, 33, 1'b0);
    add_req(REQ_BULK, 64 * 1024 + 1, 1024, 1'b0, 8, 96, 1'b1);
    // bulk: odd and even chunk counts for the final toggle
    add_req(REQ_BULK, 5, 1, 1'b0, 7, 11, 1'b1);
    add_req(REQ_BULK, 1000, 0, 1'b1, 2, 77, 1'b0);
    add_req(REQ_BULK, 1023, 1023, 1'b0, 8, 64, 1'b1);
    add_req(REQ_BULK, 1, 64, 1'b1, 12, 3, 1'b0);
    for (i = 0; i < RAND_REQS; i++) add_random_req();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || push) @(posedge clk);
    while (descriptor_q.size() != 0) @(posedge clk);
    // anything arriving now is unexpected and flagged by the monitor
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && descriptor_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule
